// ===== rtl/skt_pkg.sv =====
// Package for the sorted key table: opcodes, status codes, controller states
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package skt_pkg;
  localparam int DepthDefault = 64;
  localparam int KeyW = 32;
  localparam int GradeW = 10;
  localparam int TagW = 32;
  localparam int PosW = 6;
  localparam int RecW = KeyW + GradeW + TagW;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_DELETED  = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_RECORD   = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_INS_RD, S_INS_CMP, S_DEL_RD, S_DEL_CMP,
    S_DEL_RD2, S_DEL_MOVE, S_DUMP_RD, S_DUMP_WAIT, S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;     // capture the input beat
    logic ins_start;    // idx <= count
    logic rd_below;     // read entry idx-1
    logic ins_shift;    // write entry idx from read data, idx--
    logic ins_place;    // write new record at idx, count++
    logic del_start;    // lower=0, upper=count-1
    logic rd_mid;       // read entry mid
    logic go_upper;     // lower <= mid+1
    logic go_lower;     // upper <= mid-1
    logic del_hit;      // capture hit record, idx <= mid
    logic rd_next;      // read entry idx+1
    logic del_move;     // write entry idx from read data, idx++
    logic del_done;     // count--
    logic dump_start;   // idx <= 0
    logic rd_idx;       // read entry idx
    logic dump_adv;     // idx++
    logic [2:0] res_status;
    logic res_from_rd;  // result fields from read data
    logic res_zero;     // result fields zero, key is the input key on not-found
    logic res_last;
    logic res_load;     // load output register
  } skt_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic full;
    logic empty;
    logic idx_zero;     // insert: idx == 0
    logic key_less;     // input key < read key
    logic key_equal;
    logic search_done;  // upper < lower
    logic move_done;    // idx+1 >= count
    logic dump_final;   // idx+1 == count
    logic out_busy;     // output register occupied and not taken
  } skt_sts_t;
endpackage
`default_nettype wire

// ===== rtl/sorted_key_table.sv =====
// Sorted key table: records kept in ascending signed key order in one memory.
// Insert shifts larger entries up one at a time, delete binary-searches and
// then moves the later entries down, dump reads out every record in order.
// One item at a time.
// Reset (synchronous) empties the table; memory contents are not cleared.
`default_nettype none
module sorted_key_table #(
  parameter int Depth = skt_pkg::DepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic signed [skt_pkg::KeyW-1:0] key,
  input  wire logic [skt_pkg::GradeW-1:0] grade,
  input  wire logic [skt_pkg::TagW-1:0] tag,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [2:0] status,
  output logic signed [skt_pkg::KeyW-1:0] out_key,
  output logic [skt_pkg::GradeW-1:0] out_grade,
  output logic [skt_pkg::TagW-1:0] out_tag,
  output logic [skt_pkg::PosW-1:0] position,
  output logic last
);
  import skt_pkg::*;
  skt_cmd_t cmd;
  skt_sts_t sts;

  skt_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .sts, .cmd
  );

  skt_datapath #(.Depth(Depth)) u_dp (
    .clk, .rst, .cmd, .sts, .opcode, .key, .grade, .tag,
    .out_valid, .out_stall, .status, .out_key, .out_grade, .out_tag,
    .position, .last
  );

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.res_load) else $error("result overwritten");
  // Memory writes happen only while an item is in progress.
  a_busy_write: assert property (@(posedge clk) disable iff (rst)
    (cmd.ins_shift || cmd.ins_place || cmd.del_move) |-> in_stall)
    else $error("write while idle");
  // Insert is never placed into a full table.
  a_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_place |-> !sts.full) else $error("insert into full table");
endmodule
`default_nettype wire

// ===== rtl/skt_datapath.sv =====
// Datapath of the sorted key table: record memory, index registers, key
// comparison and output register. Uses skt_pkg.
`default_nettype none
module skt_datapath #(
  parameter int Depth = skt_pkg::DepthDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  skt_pkg::skt_cmd_t cmd,
  output skt_pkg::skt_sts_t sts,
  input  wire logic [1:0] opcode,
  input  wire logic signed [skt_pkg::KeyW-1:0] key,
  input  wire logic [skt_pkg::GradeW-1:0] grade,
  input  wire logic [skt_pkg::TagW-1:0] tag,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [2:0] status,
  output logic signed [skt_pkg::KeyW-1:0] out_key,
  output logic [skt_pkg::GradeW-1:0] out_grade,
  output logic [skt_pkg::TagW-1:0] out_tag,
  output logic [skt_pkg::PosW-1:0] position,
  output logic last
);
  import skt_pkg::*;
  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);
  localparam int SW = CW + 1; // signed search bounds

  logic [RecW-1:0] mem [Depth];
  logic [RecW-1:0] rd_data;
  logic [1:0] op_r;
  logic signed [KeyW-1:0] key_r;
  logic [GradeW-1:0] grade_r;
  logic [TagW-1:0] tag_r;
  logic [CW-1:0] count, idx;
  logic signed [SW-1:0] lower, upper;
  logic signed [SW:0] mid_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] rd_addr;
  logic signed [KeyW-1:0] rd_key;
  logic [RecW-1:0] hit_rec;
  logic [CW-1:0] hit_pos;

  assign mid_sum = {lower[SW-1], lower} + {upper[SW-1], upper};
  assign mid = CW'(mid_sum >>> 1);
  assign rd_key = rd_data[RecW-1 -: KeyW];

  always_comb begin
    rd_addr = idx;
    if (cmd.rd_below) rd_addr = idx - CW'(1);
    else if (cmd.rd_mid) rd_addr = mid;
    else if (cmd.rd_next) rd_addr = idx + CW'(1);
    else if (cmd.rd_idx) rd_addr = idx;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr[AW-1:0]];
    if (cmd.ins_shift || cmd.del_move) mem[idx[AW-1:0]] <= rd_data;
    else if (cmd.ins_place) mem[idx[AW-1:0]] <= {key_r, grade_r, tag_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r <= opcode; key_r <= key; grade_r <= grade; tag_r <= tag;
    end
    if (cmd.del_hit) begin
      hit_rec <= rd_data;
      hit_pos <= mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; idx <= '0; lower <= '0; upper <= '0;
    end else begin
      if (cmd.ins_start) idx <= count;
      if (cmd.ins_shift) idx <= idx - CW'(1);
      if (cmd.ins_place) count <= count + CW'(1);
      if (cmd.del_start) begin
        lower <= '0;
        upper <= SW'(count) - SW'(1);
      end
      if (cmd.go_upper) lower <= SW'(mid) + SW'(1);
      if (cmd.go_lower) upper <= SW'(mid) - SW'(1);
      if (cmd.del_hit) idx <= mid;
      if (cmd.del_move || cmd.dump_adv) idx <= idx + CW'(1);
      if (cmd.del_done) count <= count - CW'(1);
      if (cmd.dump_start) idx <= '0;
    end
  end

  always_comb begin
    sts.op = op_r;
    sts.full = (count >= CW'(Depth));
    sts.empty = (count == '0);
    sts.idx_zero = (idx == '0);
    sts.key_less = key_r < rd_key;
    sts.key_equal = key_r == rd_key;
    sts.search_done = upper < lower;
    sts.move_done = ({1'b0, idx} + (CW+1)'(1)) >= {1'b0, count};
    sts.dump_final = ({1'b0, idx} + (CW+1)'(1)) == {1'b0, count};
    sts.out_busy = out_valid && out_stall;
  end

  // Output register. A deleted record reports the index where the search hit
  // it; other results report the current index (zero on full, not-found or empty).
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.res_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
    if (cmd.res_load) begin
      status <= cmd.res_status;
      last <= cmd.res_last;
      if (cmd.res_zero) begin
        out_key <= (cmd.res_status == ST_NOTFOUND) ? key_r : '0;
        out_grade <= '0; out_tag <= '0; position <= '0;
      end else if (cmd.res_from_rd) begin
        {out_key, out_grade, out_tag} <= rd_data;
        position <= PosW'(idx);
      end else if (cmd.res_status == ST_DELETED) begin
        {out_key, out_grade, out_tag} <= hit_rec;
        position <= PosW'(hit_pos);
      end else begin
        out_key <= key_r; out_grade <= grade_r; out_tag <= tag_r;
        position <= (cmd.res_status == ST_FULL) ? '0 : PosW'(idx);
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/skt_ctrl.sv =====
// Controller of the sorted key table: sequences insert, delete and dump
// over the datapath. Uses skt_pkg.
`default_nettype none
module skt_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  skt_pkg::skt_sts_t sts,
  output skt_pkg::skt_cmd_t cmd
);
  import skt_pkg::*;
  state_t state, state_next;
  logic [2:0] pend_status;
  logic pend_last, pend_rd;
  logic [2:0] pend_status_next;
  logic pend_last_next, pend_rd_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend_status <= ST_INSERTED; pend_last <= 1'b0; pend_rd <= 1'b0;
    end else begin
      state <= state_next;
      pend_status <= pend_status_next; pend_last <= pend_last_next;
      pend_rd <= pend_rd_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_status_next = pend_status;
    pend_last_next = pend_last;
    pend_rd_next = pend_rd;
    case (state)
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        case (sts.op)
          OP_INSERT: state_next = S_INS_RD;
          OP_DELETE: state_next = S_DEL_RD;
          OP_DUMP:   state_next = S_DUMP_RD;
          default:   state_next = S_IDLE;
        endcase
        if (sts.op == OP_INSERT && sts.full) begin
          state_next = S_OUT; pend_status_next = ST_FULL;
          pend_last_next = 1'b1; pend_rd_next = 1'b0;
        end
        if (sts.op == OP_DUMP && sts.empty) begin
          state_next = S_OUT; pend_status_next = ST_EMPTY;
          pend_last_next = 1'b1; pend_rd_next = 1'b0;
        end
      end
      S_INS_RD: begin
        if (sts.idx_zero) begin
          state_next = S_OUT; pend_status_next = ST_INSERTED;
          pend_last_next = 1'b1; pend_rd_next = 1'b0;
        end else state_next = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (sts.key_less) state_next = S_INS_RD;
        else begin
          state_next = S_OUT; pend_status_next = ST_INSERTED;
          pend_last_next = 1'b1; pend_rd_next = 1'b0;
        end
      end
      S_DEL_RD: begin
        if (sts.search_done) begin
          state_next = S_OUT; pend_status_next = ST_NOTFOUND;
          pend_last_next = 1'b1; pend_rd_next = 1'b0;
        end else state_next = S_DEL_CMP;
      end
      S_DEL_CMP: state_next = sts.key_equal ? S_DEL_RD2 : S_DEL_RD;
      S_DEL_RD2: begin
        if (sts.move_done) begin
          state_next = S_OUT; pend_status_next = ST_DELETED;
          pend_last_next = 1'b1; pend_rd_next = 1'b0;
        end else state_next = S_DEL_MOVE;
      end
      S_DEL_MOVE: state_next = S_DEL_RD2;
      S_DUMP_RD: state_next = S_DUMP_WAIT;
      S_DUMP_WAIT: begin
        if (!sts.out_busy) begin
          state_next = sts.dump_final ? S_IDLE : S_DUMP_RD;
        end
      end
      S_OUT: if (!sts.out_busy) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: cmd.latch_in = 1'b1;
      S_DECODE: begin
        cmd.ins_start = (sts.op == OP_INSERT);
        cmd.del_start = (sts.op == OP_DELETE);
        cmd.dump_start = (sts.op == OP_DUMP);
      end
      S_INS_RD: cmd.rd_below = 1'b1;
      S_INS_CMP: cmd.ins_shift = sts.key_less;
      S_DEL_RD: cmd.rd_mid = 1'b1;
      S_DEL_CMP: begin
        cmd.del_hit = sts.key_equal;
        cmd.go_upper = !sts.key_equal && !sts.key_less;
        cmd.go_lower = !sts.key_equal && sts.key_less;
      end
      S_DEL_RD2: cmd.rd_next = 1'b1;
      S_DEL_MOVE: cmd.del_move = 1'b1;
      S_DUMP_RD: cmd.rd_idx = 1'b1;
      S_DUMP_WAIT: begin
        cmd.rd_idx = 1'b1;
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1; cmd.res_status = ST_RECORD;
          cmd.res_from_rd = 1'b1; cmd.res_last = sts.dump_final;
          cmd.dump_adv = 1'b1;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1; cmd.res_status = pend_status;
          cmd.res_last = pend_last; cmd.res_from_rd = pend_rd;
          cmd.res_zero = (pend_status == ST_NOTFOUND) || (pend_status == ST_EMPTY);
          cmd.ins_place = (pend_status == ST_INSERTED);
          cmd.del_done = (pend_status == ST_DELETED);
        end
      end
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

// ===== verif/sorted_key_table_checker.sv =====
// Checker for the sorted key table: watches both channels, keeps its own
// sorted copy of the table, and compares every result beat. Depends on skt_pkg.
module sorted_key_table_checker #(
  parameter int Depth = 64
) (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic [1:0] opcode,
  input logic signed [31:0] key,
  input logic [9:0] grade,
  input logic [31:0] tag,
  input logic out_valid,
  input logic out_stall,
  input logic [2:0] status,
  input logic signed [31:0] out_key,
  input logic [9:0] out_grade,
  input logic [31:0] out_tag,
  input logic [5:0] position,
  input logic last,
  output int errors,
  output int pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  typedef struct packed {
    logic [2:0] st;
    logic signed [31:0] k;
    logic [9:0] g;
    logic [31:0] t;
    logic [5:0] pos;
    logic lst;
  } table_result_t;

  logic signed [31:0] keys[Depth];
  logic [9:0] grades[Depth];
  logic [31:0] tags[Depth];
  int fill;
  table_result_t expected_results[$];

  function automatic table_result_t mk(logic [2:0] st, logic signed [31:0] k,
                                       logic [9:0] g, logic [31:0] t, int p, logic l);
    table_result_t r;
    r.st = st; r.k = k; r.g = g; r.t = t; r.pos = p[5:0]; r.lst = l;
    return r;
  endfunction

  task automatic expect_beat(table_result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic apply_command(logic [1:0] op, logic signed [31:0] k, logic [9:0] g,
                               logic [31:0] t);
    int i, lo, hi, mid;
    bit hit;
    if (op == OP_INSERT) begin
      if (fill >= Depth) begin
        expect_beat(mk(ST_FULL, k, g, t, 0, 1'b1));
      end else begin
        i = fill;
        while (i > 0 && k < keys[i-1]) begin
          keys[i] = keys[i-1]; grades[i] = grades[i-1]; tags[i] = tags[i-1];
          i--;
        end
        keys[i] = k; grades[i] = g; tags[i] = t;
        fill++;
        expect_beat(mk(ST_INSERTED, k, g, t, i, 1'b1));
      end
    end else if (op == OP_DELETE) begin
      lo = 0; hi = fill - 1; hit = 0;
      while (hi >= lo && !hit) begin
        mid = (lo + hi) / 2;
        if (keys[mid] == k) begin
          hit = 1;
          expect_beat(mk(ST_DELETED, keys[mid], grades[mid], tags[mid], mid, 1'b1));
          for (i = mid; i + 1 < fill; i++) begin
            keys[i] = keys[i+1]; grades[i] = grades[i+1]; tags[i] = tags[i+1];
          end
          fill--;
        end else if (keys[mid] < k) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
      if (!hit) expect_beat(mk(ST_NOTFOUND, k, 0, 0, 0, 1'b1));
    end else if (op == OP_DUMP) begin
      if (fill == 0) expect_beat(mk(ST_EMPTY, 0, 0, 0, 0, 1'b1));
      for (i = 0; i < fill; i++)
        expect_beat(mk(ST_RECORD, keys[i], grades[i], tags[i], i, i + 1 == fill));
    end
  endtask

  always @(posedge clk) begin
    table_result_t e;
    if (rst) begin
      fill = 0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) apply_command(opcode, key, grade, tag);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d key %0d", status, out_key);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (status !== e.st) begin
            $error("status: expected %0d, got %0d", e.st, status); errors++;
          end
          if (out_key !== e.k) begin
            $error("out_key: expected %0d, got %0d", e.k, out_key); errors++;
          end
          if (out_grade !== e.g) begin
            $error("out_grade: expected %0d, got %0d", e.g, out_grade); errors++;
          end
          if (out_tag !== e.t) begin
            $error("out_tag: expected %h, got %h", e.t, out_tag); errors++;
          end
          if (position !== e.pos) begin
            $error("position: expected %0d, got %0d", e.pos, position); errors++;
          end
          if (last !== e.lst) begin
            $error("last: expected %0d, got %0d", e.lst, last); errors++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    fill = 0;
  end
endmodule

// ===== verif/tb_sorted_key_table.sv =====
// Top of the sorted key table testbench: clock, reset, command stimulus and
// result-side stalls. Depends on skt_pkg, sorted_key_table and its checker.
module tb_sorted_key_table;
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  // The fourth opcode value is ignored by the table.
  localparam logic [1:0] OP_IGNORED = 2'd3;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] opcode = OP_DUMP;
  logic signed [31:0] key = 0;
  logic [9:0] grade = 0;
  logic [31:0] tag = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [2:0] status;
  logic signed [31:0] out_key;
  logic [9:0] out_grade;
  logic [31:0] out_tag;
  logic [5:0] position;
  logic last;
  int errors, pending;
  bit hold_results = 0;
  bit stimulus_done = 0;
  logic signed [31:0] used_keys[$];

  sorted_key_table dut (.*);
  sorted_key_table_checker chk (.*);

  initial forever #6 clk = ~clk;

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 4) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one beat and returns after it has been accepted.
  task automatic send_command(logic [1:0] op, logic signed [31:0] k, logic [9:0] g,
                              logic [31:0] t);
    opcode <= op; key <= k; grade <= g; tag <= t; in_valid <= 1;
    do @(posedge clk); while (in_stall);
    if (op == OP_INSERT) used_keys.insert(used_keys.size(), k);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_key();
    if (used_keys.size() > 0 && $urandom_range(0, 2) != 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 40)) - 20;
  endfunction

  task automatic random_command();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) send_command(OP_INSERT, pick_key(), $urandom_range(0, 1023), $urandom);
    else if (r < 16) send_command(OP_DELETE, pick_key(), $urandom, $urandom);
    else if (r < 19) send_command(OP_DUMP, $urandom, $urandom, $urandom);
    else send_command(OP_IGNORED, $urandom, $urandom, $urandom);
  endtask

  // Result side: random stalls, plus a long hold while the table is busy.
  initial begin
    int n;
    @(negedge rst);
    while (!stimulus_done) begin
      if (hold_results) begin
        out_stall <= 1;
        repeat (300) @(posedge clk);
        hold_results = 0;
      end
      n = pick_gap();
      out_stall <= (n != 0);
      repeat (n) @(posedge clk);
      out_stall <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    out_stall <= 0;
  end

  initial begin
    int i;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed part: empty table, extremes, duplicates, misses, ignored opcode.
    send_command(OP_DUMP, 0, 0, 0);
    send_command(OP_DELETE, 5, 0, 0);
    send_command(OP_INSERT, 32'sh7fffffff, 10'h3ff, 32'hffffffff);
    send_command(OP_INSERT, 32'sh80000000, 0, 0);
    send_command(OP_INSERT, 0, 1000, 32'h12345678);
    send_command(OP_INSERT, 0, 1, 32'h1);
    send_command(OP_INSERT, -1, 999, 32'haaaa5555);
    send_command(OP_IGNORED, 7, 7, 7);
    send_command(OP_DUMP, 0, 0, 0);
    send_command(OP_DELETE, 0, 0, 0);
    send_command(OP_DELETE, 3, 0, 0);
    send_command(OP_DELETE, 32'sh80000000, 0, 0);
    send_command(OP_DELETE, 32'sh7fffffff, 0, 0);
    send_command(OP_DUMP, 0, 0, 0);
    // Fill to overflow; the results are held back so the input stalls.
    hold_results = 1;
    for (i = 0; i < 62; i++)
      send_command(OP_INSERT, $urandom_range(0, 30), $urandom_range(0, 1023), $urandom);
    send_command(OP_INSERT, 1, 2, 3);
    send_command(OP_DUMP, 0, 0, 0);
    // Pause until every expected result has arrived.
    drain();
    for (i = 0; i < 20; i++) send_command(OP_DELETE, pick_key(), 0, 0);
    for (i = 0; i < 25; i++) begin
      random_command();
      idle_gap(pick_gap());
    end
    in_valid <= 0;
    stimulus_done = 1;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/skt_pkg.sv
rtl/skt_datapath.sv
rtl/skt_ctrl.sv
rtl/sorted_key_table.sv
verif/sorted_key_table_checker.sv
verif/tb_sorted_key_table.sv
